FILE: src/bounded_weight_string_unrank_assert.svh
// assertion helpers for the unrank block, clocked on aclk and held off during reset
`ifndef BOUNDED_WEIGHT_STRING_UNRANK_ASSERT_SVH
`define BOUNDED_WEIGHT_STRING_UNRANK_ASSERT_SVH

// same-cycle implication
`define BWSU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BWSU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/bwsu_pkg.sv
`default_nettype none
package bwsu_pkg;

    localparam int MAX_WORD_BITS = 31;
    localparam int LEN_W         = 5;
    localparam int RANK_W        = 32;
    localparam int WORD_W        = 31;
    localparam int CNT_W         = 32;
    localparam int TBL_COLS      = 32;
    localparam int TBL_AW        = 2 * LEN_W;
    localparam int TBL_DEPTH     = 1 << TBL_AW;
    localparam int QUEUE_DEPTH   = 2;

    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [RANK_W-1:0] rank_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [WORD_W-1:0] word_t;
    typedef logic [TBL_AW-1:0] addr_t;

    // one classified request as it sits in the queue
    typedef struct packed {
        len_t  n;
        len_t  k;
        rank_t r;
    } req_t;

    // two-port read request into the count table
    typedef struct packed {
        logic  en;
        addr_t addr0;
        addr_t addr1;
    } tbl_rd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_STEP,
        ST_DONE
    } back_state_t;

    // table entry f(k,m) lives at row m, column k
    function automatic addr_t tbl_addr(input len_t k, input len_t m);
        return {m, k};
    endfunction

endpackage
`default_nettype wire

FILE: src/bounded_weight_string_unrank.sv
// Returns the word at a 1-based rank among all word_length-bit words with at most max_ones
// one bits, in ascending order; a rank past the set size gives a zero word with
// rank_too_large set. A count table f(k,m) of 1024 entries is built in a memory after reset,
// one entry a cycle, and no request is started until the table is full (requests are still
// taken into the two-entry input queue meanwhile). A request then goes through the back end
// in steps: it is taken from the queue while the table is read, its rank is checked, each
// output bit is made in a step of its own with the next count read from the table's two read
// ports, and the result is handed off to an output register, where it waits while the next
// request starts. A zero length or a rank past the set skips the bit steps. While the output
// register still holds a beat that m_ready has not taken, the back end waits in its hand-off
// step.
`default_nettype none
module bounded_weight_string_unrank (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire bwsu_pkg::len_t  s_word_length,
    input  wire bwsu_pkg::len_t  s_max_ones,
    input  wire bwsu_pkg::rank_t s_rank,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output bwsu_pkg::word_t      m_word_value,
    output logic                 m_rank_too_large
);

`include "bounded_weight_string_unrank_assert.svh"

    logic              q_valid;
    bwsu_pkg::req_t    q_head;
    logic              q_pop;
    logic              tbl_ready;
    bwsu_pkg::tbl_rd_t tbl_rd;
    bwsu_pkg::cnt_t    rd0;
    bwsu_pkg::cnt_t    rd1;

    bwsu_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_word_length (s_word_length),
        .s_max_ones    (s_max_ones),
        .s_rank        (s_rank),
        .q_valid       (q_valid),
        .q_head        (q_head),
        .q_pop         (q_pop)
    );

    bwsu_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd      (tbl_rd),
        .rd0     (rd0),
        .rd1     (rd1),
        .ready   (tbl_ready)
    );

    bwsu_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (q_valid),
        .q_head           (q_head),
        .q_pop            (q_pop),
        .tbl_ready        (tbl_ready),
        .tbl_rd           (tbl_rd),
        .rd0              (rd0),
        .rd1              (rd1),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_word_value     (m_word_value),
        .m_rank_too_large (m_rank_too_large)
    );

    `BWSU_ASSERT_NOW(a_pop_not_empty, q_pop, q_valid, "queue popped while empty")
    `BWSU_ASSERT_NOW(a_pop_after_fill, q_pop, tbl_ready, "request started before table fill")
    `BWSU_ASSERT_NEXT(a_pop_spacing, q_pop, !q_pop, "back end took two requests in a row")
    `BWSU_ASSERT_NOW(a_flag_zero_word, m_valid && m_rank_too_large, m_word_value == '0,
                     "flagged result carries a nonzero word")

endmodule
`default_nettype wire

FILE: src/bwsu_front.sv
`default_nettype none
module bwsu_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire bwsu_pkg::len_t  s_word_length,
    input  wire bwsu_pkg::len_t  s_max_ones,
    input  wire bwsu_pkg::rank_t s_rank,
    output logic                 q_valid,
    output bwsu_pkg::req_t       q_head,
    input  wire logic            q_pop
);

    bwsu_pkg::req_t q_reg [bwsu_pkg::QUEUE_DEPTH];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;

    bwsu_pkg::len_t n_sat;
    bwsu_pkg::req_t cls;
    logic           push;
    logic           pop;

    // saturate length, clip the ones budget to the length, rank zero reads as one
    always_comb begin
        n_sat = (s_word_length > bwsu_pkg::len_t'(bwsu_pkg::MAX_WORD_BITS)) ?
                bwsu_pkg::len_t'(bwsu_pkg::MAX_WORD_BITS) : s_word_length;
        cls.n = n_sat;
        cls.k = (s_max_ones > n_sat) ? n_sat : s_max_ones;
        cls.r = (s_rank == '0) ? bwsu_pkg::rank_t'(1) : s_rank;
    end

    assign s_ready = (count_reg != 2'(bwsu_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != 2'd0);
    assign q_head  = q_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule
`default_nettype wire

FILE: src/bwsu_table.sv
`default_nettype none
module bwsu_table (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire bwsu_pkg::tbl_rd_t rd,
    output bwsu_pkg::cnt_t         rd0,
    output bwsu_pkg::cnt_t         rd1,
    output logic                   ready
);

    bwsu_pkg::cnt_t mem [bwsu_pkg::TBL_DEPTH];
    bwsu_pkg::cnt_t row_reg [bwsu_pkg::TBL_COLS];
    bwsu_pkg::cnt_t held_reg;
    bwsu_pkg::cnt_t rd0_reg, rd1_reg;

    logic [bwsu_pkg::TBL_AW:0] fill_cnt_reg, fill_cnt_next;
    logic                      filling;
    bwsu_pkg::len_t            fill_k;
    bwsu_pkg::len_t            fill_m;
    bwsu_pkg::cnt_t            fill_val;

    assign filling = !fill_cnt_reg[bwsu_pkg::TBL_AW];
    assign fill_k  = fill_cnt_reg[bwsu_pkg::LEN_W-1:0];
    assign fill_m  = fill_cnt_reg[bwsu_pkg::TBL_AW-1:bwsu_pkg::LEN_W];
    assign ready   = !filling;

    // pascal step: f(k,m) = f(k,m-1) + f(k-1,m-1); held_reg carries f(k-1,m-1)
    assign fill_val = (fill_m == '0 || fill_k == '0) ? bwsu_pkg::cnt_t'(1) :
                      row_reg[fill_k] + held_reg;

    assign fill_cnt_next = filling ? fill_cnt_reg + 1'b1 : fill_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_cnt_reg <= '0;
        end else begin
            fill_cnt_reg <= fill_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (filling) begin
            mem[bwsu_pkg::tbl_addr(fill_k, fill_m)] <= fill_val;
            row_reg[fill_k] <= fill_val;
            held_reg        <= row_reg[fill_k];
        end
    end

    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rd0_reg <= mem[rd.addr0];
            rd1_reg <= mem[rd.addr1];
        end
    end

    assign rd0 = rd0_reg;
    assign rd1 = rd1_reg;

endmodule
`default_nettype wire

FILE: src/bwsu_back.sv
`default_nettype none
module bwsu_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            q_valid,
    input  wire bwsu_pkg::req_t  q_head,
    output logic                 q_pop,
    input  wire logic            tbl_ready,
    output bwsu_pkg::tbl_rd_t    tbl_rd,
    input  wire bwsu_pkg::cnt_t  rd0,
    input  wire bwsu_pkg::cnt_t  rd1,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output bwsu_pkg::word_t      m_word_value,
    output logic                 m_rank_too_large
);

    bwsu_pkg::back_state_t state_reg, state_next;

    bwsu_pkg::len_t  m_reg, m_next;
    bwsu_pkg::len_t  k_reg, k_next;
    bwsu_pkg::rank_t r_reg, r_next;
    logic            z_sel_reg, z_sel_next;
    bwsu_pkg::word_t word_reg, word_next;
    logic            flag_reg, flag_next;

    logic            out_valid_reg, out_valid_next;
    bwsu_pkg::word_t out_word_reg;
    logic            out_flag_reg;

    bwsu_pkg::cnt_t  z;
    logic            take_one;
    logic            too_large;
    logic            out_load;

    // z is f(k, m-1): the count of words that keep the current bit at zero
    assign z         = z_sel_reg ? rd1 : rd0;
    assign take_one  = (bwsu_pkg::cnt_t'(r_reg) > z) && (k_reg != '0);
    assign too_large = bwsu_pkg::cnt_t'(r_reg) > rd0;
    assign out_load  = (state_reg == bwsu_pkg::ST_DONE) && (!out_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bwsu_pkg::ST_IDLE: begin
                if (q_valid && tbl_ready) begin
                    state_next = bwsu_pkg::ST_CHECK;
                end
            end
            bwsu_pkg::ST_CHECK: begin
                if (too_large || m_reg == '0) begin
                    state_next = bwsu_pkg::ST_DONE;
                end else begin
                    state_next = bwsu_pkg::ST_STEP;
                end
            end
            bwsu_pkg::ST_STEP: begin
                if (m_reg == bwsu_pkg::len_t'(1)) begin
                    state_next = bwsu_pkg::ST_DONE;
                end
            end
            bwsu_pkg::ST_DONE: begin
                if (out_load) begin
                    state_next = bwsu_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bwsu_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_next       = m_reg;
        k_next       = k_reg;
        r_next       = r_reg;
        z_sel_next   = z_sel_reg;
        word_next    = word_reg;
        flag_next    = flag_reg;
        q_pop        = 1'b0;
        tbl_rd.en    = 1'b0;
        // prefetch both possible next counts: budget kept or budget spent
        tbl_rd.addr0 = bwsu_pkg::tbl_addr(k_reg, m_reg - bwsu_pkg::len_t'(2));
        tbl_rd.addr1 = bwsu_pkg::tbl_addr(k_reg - bwsu_pkg::len_t'(1),
                                          m_reg - bwsu_pkg::len_t'(2));
        case (state_reg)
            bwsu_pkg::ST_IDLE: begin
                tbl_rd.addr0 = bwsu_pkg::tbl_addr(q_head.k, q_head.n);
                tbl_rd.addr1 = bwsu_pkg::tbl_addr(q_head.k,
                                                  q_head.n - bwsu_pkg::len_t'(1));
                tbl_rd.en    = q_valid && tbl_ready;
                q_pop        = q_valid && tbl_ready;
                m_next       = q_head.n;
                k_next       = q_head.k;
                r_next       = q_head.r;
            end
            bwsu_pkg::ST_CHECK: begin
                word_next  = '0;
                flag_next  = too_large;
                z_sel_next = 1'b1;
            end
            bwsu_pkg::ST_STEP: begin
                tbl_rd.en  = 1'b1;
                word_next  = {word_reg[bwsu_pkg::WORD_W-2:0], take_one};
                z_sel_next = take_one;
                m_next     = m_reg - bwsu_pkg::len_t'(1);
                if (take_one) begin
                    r_next = r_reg - bwsu_pkg::rank_t'(z);
                    k_next = k_reg - bwsu_pkg::len_t'(1);
                end
            end
            bwsu_pkg::ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= bwsu_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_reg     <= m_next;
        k_reg     <= k_next;
        r_reg     <= r_next;
        z_sel_reg <= z_sel_next;
        word_reg  <= word_next;
        flag_reg  <= flag_next;
        if (out_load) begin
            out_word_reg <= flag_reg ? '0 : word_reg;
            out_flag_reg <= flag_reg;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_word_value     = out_word_reg;
    assign m_rank_too_large = out_flag_reg;

endmodule
`default_nettype wire
